// ===== rtl/core/potc_pkg.sv =====
// ----------------------------------------------------------------------------
// potc_pkg: shared types and constants of the periodic/one-shot timer table
// Opcodes, result kinds, cell commands and the control word of one slot.
// ----------------------------------------------------------------------------
package potc_pkg;

	localparam int unsigned HANDLE_W = 31;
	localparam int unsigned ACTION_W = 8;
	localparam int unsigned TICK_W   = 64;
	localparam int unsigned IVAL_W   = 32;

	localparam logic [HANDLE_W-1:0] HANDLE_MAX = 31'h7FFF_FFFF;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_REG   = 2'd1,
		OP_UNREG = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		KIND_REPLY = 2'd0,
		KIND_FIRE  = 2'd1,
		KIND_END   = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_INSERT = 2'd1,
		CELL_ROTATE = 2'd2,
		CELL_DROP   = 2'd3
	} cell_op_t;

	typedef struct packed {
		cell_op_t            op;
		logic [HANDLE_W-1:0] target;
	} cell_cmd_t;

	typedef struct packed {
		logic                used;
		logic                active;
		logic                single;
		logic [HANDLE_W-1:0] handle;
		logic [ACTION_W-1:0] action;
	} slot_ctl_t;

	typedef struct packed {
		logic all_used;
		logic found;
	} chain_t;

endpackage

// ===== rtl/core/potc_if.sv =====
// ----------------------------------------------------------------------------
// potc_if: request and response channels of the timer table
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface potc_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [7:0]  callback_id;
	logic [31:0] interval;
	logic        oneshot;
	logic [30:0] target_handle;
	logic [63:0] tick_value;

	modport source (output valid, op, callback_id, interval, oneshot, target_handle,
		tick_value, input ready);
	modport sink (input valid, op, callback_id, interval, oneshot, target_handle,
		tick_value, output ready);
endinterface

interface potc_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic        accepted;
	logic [30:0] handle;
	logic [7:0]  fired_callback;
	logic [63:0] fired_tick;
	logic        last;

	modport source (output valid, kind, accepted, handle, fired_callback, fired_tick,
		last, input ready);
	modport sink (input valid, kind, accepted, handle, fired_callback, fired_tick,
		last, output ready);
endinterface

// ===== rtl/core/potc_cell.sv =====
// ----------------------------------------------------------------------------
// potc_cell: one timer slot in the ordered chain
// Holds a slot; inserts from the newer neighbor, rotates from the older one,
// and deactivates itself on the newest handle match.
// ----------------------------------------------------------------------------
module potc_cell #(
	parameter int unsigned COUNT_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  potc_pkg::cell_cmd_t    cmd,
	input  potc_pkg::slot_ctl_t    prev_ctl,
	input  logic [COUNT_WIDTH-1:0] prev_period,
	input  logic [COUNT_WIDTH-1:0] prev_left,
	input  potc_pkg::slot_ctl_t    next_ctl,
	input  logic [COUNT_WIDTH-1:0] next_period,
	input  logic [COUNT_WIDTH-1:0] next_left,
	input  potc_pkg::chain_t       chain_in,
	output potc_pkg::chain_t       chain_out,
	output potc_pkg::slot_ctl_t    ctl,
	output logic [COUNT_WIDTH-1:0] period,
	output logic [COUNT_WIDTH-1:0] left
);

	logic                             used_q;
	logic                             active_q;
	logic                             single_q;
	logic [potc_pkg::HANDLE_W-1:0]    handle_q;
	logic [potc_pkg::ACTION_W-1:0]    action_q;
	logic [COUNT_WIDTH-1:0]           period_q;
	logic [COUNT_WIDTH-1:0]           left_q;
	logic                             match;
	logic                             load_prev;
	logic                             load_next;

	assign match     = used_q && (handle_q == cmd.target);
	assign load_prev = (cmd.op == potc_pkg::CELL_INSERT) && chain_in.all_used;
	assign load_next = (cmd.op == potc_pkg::CELL_ROTATE);

	assign chain_out.all_used = chain_in.all_used && used_q;
	assign chain_out.found    = chain_in.found || match;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q   <= 1'b0;
			active_q <= 1'b0;
		end else if (load_prev) begin
			used_q   <= prev_ctl.used;
			active_q <= prev_ctl.active;
		end else if (load_next) begin
			used_q   <= next_ctl.used;
			active_q <= next_ctl.active;
		end else if (cmd.op == potc_pkg::CELL_DROP && match && !chain_in.found) begin
			active_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_prev) begin
			single_q <= prev_ctl.single;
			handle_q <= prev_ctl.handle;
			action_q <= prev_ctl.action;
			period_q <= prev_period;
			left_q   <= prev_left;
		end else if (load_next) begin
			single_q <= next_ctl.single;
			handle_q <= next_ctl.handle;
			action_q <= next_ctl.action;
			period_q <= next_period;
			left_q   <= next_left;
		end
	end

	assign ctl.used   = used_q;
	assign ctl.active = active_q;
	assign ctl.single = single_q;
	assign ctl.handle = handle_q;
	assign ctl.action = action_q;
	assign period     = period_q;
	assign left       = left_q;

endmodule

// ===== rtl/core/periodic_oneshot_timer_table_core.sv =====
// ----------------------------------------------------------------------------
// periodic_oneshot_timer_table_core: bounded table of periodic/one-shot timers
// Slots sit in a chain of cells ordered newest first; a tick rotates the chain
// once through a decrement unit at its head.
// ----------------------------------------------------------------------------
// A register or unregister word is handled in the idle state and leaves the block
// idle; a register answers with one reply word. A tick word rotates the slot
// chain once, one cell per cycle through the decrement unit at the head while
// the response side can take a word, emitting fire words in newest-first order,
// and then the end word. Only one word is in progress at a time.
module periodic_oneshot_timer_table_core #(
	parameter int unsigned SLOTS       = 16,
	parameter int unsigned COUNT_WIDTH = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	potc_req_if.sink     req,
	potc_rsp_if.source   rsp
);

	localparam int unsigned STEP_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_TICK,
		S_END
	} state_t;

	state_t                          state_q;
	logic [STEP_W-1:0]               step_q;
	logic [potc_pkg::HANDLE_W-1:0]   handle_q;
	logic [potc_pkg::TICK_W-1:0]     tick_q;

	logic                            out_vq;
	potc_pkg::kind_t                 out_kind_q;
	logic                            out_acc_q;
	logic [potc_pkg::HANDLE_W-1:0]   out_handle_q;
	logic [potc_pkg::ACTION_W-1:0]   out_cb_q;
	logic [potc_pkg::TICK_W-1:0]     out_tick_q;
	logic                            out_last_q;

	potc_pkg::slot_ctl_t             ctl_w    [SLOTS];
	logic [COUNT_WIDTH-1:0]          period_w [SLOTS];
	logic [COUNT_WIDTH-1:0]          left_w   [SLOTS];
	potc_pkg::slot_ctl_t             pctl_w   [SLOTS];
	logic [COUNT_WIDTH-1:0]          pper_w   [SLOTS];
	logic [COUNT_WIDTH-1:0]          pleft_w  [SLOTS];
	potc_pkg::slot_ctl_t             nctl_w   [SLOTS];
	logic [COUNT_WIDTH-1:0]          nper_w   [SLOTS];
	logic [COUNT_WIDTH-1:0]          nleft_w  [SLOTS];
	potc_pkg::chain_t                chain_w  [SLOTS+1];

	potc_pkg::cell_cmd_t             cmd;
	potc_pkg::slot_ctl_t             new_ctl;
	logic [COUNT_WIDTH-1:0]          new_count;
	potc_pkg::slot_ctl_t             head_ctl;
	logic [COUNT_WIDTH-1:0]          head_left;
	logic [COUNT_WIDTH-1:0]          head_dec;
	logic                            head_fire;
	logic                            can_emit;
	logic                            in_fire;
	logic                            reg_ok;
	logic                            emit;
	potc_pkg::kind_t                 e_kind;
	logic                            e_acc;
	logic [potc_pkg::HANDLE_W-1:0]   e_handle;
	logic [potc_pkg::ACTION_W-1:0]   e_cb;
	logic [potc_pkg::TICK_W-1:0]     e_tick;
	logic                            e_last;

	assign can_emit  = !out_vq || rsp.ready;
	assign req.ready = (state_q == S_IDLE) && can_emit;
	assign in_fire   = req.valid && req.ready;

	generate
		if (COUNT_WIDTH >= potc_pkg::IVAL_W) begin : g_wide
			assign new_count = COUNT_WIDTH'(req.interval);
		end else begin : g_narrow
			assign new_count = (|req.interval[potc_pkg::IVAL_W-1:COUNT_WIDTH]) ?
				{COUNT_WIDTH{1'b1}} : req.interval[COUNT_WIDTH-1:0];
		end
	endgenerate

	assign new_ctl.used   = 1'b1;
	assign new_ctl.active = 1'b1;
	assign new_ctl.single = req.oneshot;
	assign new_ctl.handle = handle_q;
	assign new_ctl.action = req.callback_id;

	assign reg_ok = (req.callback_id != '0) && (req.interval != '0)
		&& !chain_w[SLOTS].all_used;

	// Head of the chain: decrement, fire, reload or retire.
	assign head_dec  = left_w[0] - COUNT_WIDTH'(1);
	assign head_fire = ctl_w[0].used && ctl_w[0].active && (head_dec == '0);

	always_comb begin
		head_ctl  = ctl_w[0];
		head_left = left_w[0];
		if (ctl_w[0].active) begin
			head_left = head_fire ? period_w[0] : head_dec;
			if (head_fire && ctl_w[0].single) begin
				head_ctl.active = 1'b0;
			end
		end
		head_ctl.used = ctl_w[0].used && head_ctl.active;
	end

	always_comb begin
		cmd.op     = potc_pkg::CELL_HOLD;
		cmd.target = req.target_handle;
		if (in_fire && req.op == potc_pkg::OP_REG && reg_ok) begin
			cmd.op = potc_pkg::CELL_INSERT;
		end else if (in_fire && req.op == potc_pkg::OP_UNREG && req.target_handle != '0) begin
			cmd.op = potc_pkg::CELL_DROP;
		end else if (state_q == S_TICK && can_emit) begin
			cmd.op = potc_pkg::CELL_ROTATE;
		end
	end

	assign chain_w[0].all_used = 1'b1;
	assign chain_w[0].found    = 1'b0;

	generate
		for (genvar k = 0; k < SLOTS; k++) begin : g_cell
			if (k == 0) begin : g_head
				assign pctl_w[k]  = new_ctl;
				assign pper_w[k]  = new_count;
				assign pleft_w[k] = new_count;
			end else begin : g_mid
				assign pctl_w[k]  = ctl_w[k-1];
				assign pper_w[k]  = period_w[k-1];
				assign pleft_w[k] = left_w[k-1];
			end
			if (k == SLOTS - 1) begin : g_tail
				assign nctl_w[k]  = head_ctl;
				assign nper_w[k]  = period_w[0];
				assign nleft_w[k] = head_left;
			end else begin : g_body
				assign nctl_w[k]  = ctl_w[k+1];
				assign nper_w[k]  = period_w[k+1];
				assign nleft_w[k] = left_w[k+1];
			end
			potc_cell #(
				.COUNT_WIDTH (COUNT_WIDTH)
			) u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.cmd         (cmd),
				.prev_ctl    (pctl_w[k]),
				.prev_period (pper_w[k]),
				.prev_left   (pleft_w[k]),
				.next_ctl    (nctl_w[k]),
				.next_period (nper_w[k]),
				.next_left   (nleft_w[k]),
				.chain_in    (chain_w[k]),
				.chain_out   (chain_w[k+1]),
				.ctl         (ctl_w[k]),
				.period      (period_w[k]),
				.left        (left_w[k])
			);
		end
	endgenerate

	always_comb begin
		emit     = 1'b0;
		e_kind   = potc_pkg::KIND_REPLY;
		e_acc    = 1'b0;
		e_handle = '0;
		e_cb     = '0;
		e_tick   = '0;
		e_last   = 1'b1;
		case (state_q)
			S_IDLE: begin
				if (in_fire && req.op == potc_pkg::OP_REG) begin
					emit     = 1'b1;
					e_acc    = reg_ok;
					e_handle = reg_ok ? handle_q : '0;
				end
			end
			S_TICK: begin
				if (can_emit && head_fire) begin
					emit     = 1'b1;
					e_kind   = potc_pkg::KIND_FIRE;
					e_handle = ctl_w[0].handle;
					e_cb     = ctl_w[0].action;
					e_tick   = tick_q;
					e_last   = 1'b0;
				end
			end
			S_END: begin
				if (can_emit) begin
					emit   = 1'b1;
					e_kind = potc_pkg::KIND_END;
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			step_q   <= '0;
			handle_q <= potc_pkg::HANDLE_W'(1);
			out_vq   <= 1'b0;
		end else begin
			if (emit) begin
				out_vq <= 1'b1;
			end else if (rsp.ready) begin
				out_vq <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_fire && req.op == potc_pkg::OP_TICK) begin
						state_q <= S_TICK;
						step_q  <= '0;
					end
					if (in_fire && req.op == potc_pkg::OP_REG && reg_ok) begin
						handle_q <= (handle_q == potc_pkg::HANDLE_MAX) ?
							potc_pkg::HANDLE_W'(1) : handle_q + potc_pkg::HANDLE_W'(1);
					end
				end
				S_TICK: begin
					if (can_emit) begin
						step_q <= step_q + STEP_W'(1);
						if (step_q == STEP_W'(SLOTS - 1)) begin
							state_q <= S_END;
						end
					end
				end
				S_END: begin
					if (can_emit) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && req.op == potc_pkg::OP_TICK) begin
			tick_q <= req.tick_value;
		end
		if (emit) begin
			out_kind_q   <= e_kind;
			out_acc_q    <= e_acc;
			out_handle_q <= e_handle;
			out_cb_q     <= e_cb;
			out_tick_q   <= e_tick;
			out_last_q   <= e_last;
		end
	end

	assign rsp.valid          = out_vq;
	assign rsp.kind           = out_kind_q;
	assign rsp.accepted       = out_acc_q;
	assign rsp.handle         = out_handle_q;
	assign rsp.fired_callback = out_cb_q;
	assign rsp.fired_tick     = out_tick_q;
	assign rsp.last           = out_last_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		handle_q != '0)
		else $error("handle counter reached zero");

	assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && req.op == potc_pkg::OP_TICK) |=> (state_q == S_TICK && step_q == '0))
		else $error("tick word did not start a rotation");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_END) |-> ($past(state_q) == S_TICK || $past(state_q) == S_END))
		else $error("end of tick reached without a rotation");

	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == potc_pkg::CELL_INSERT) |=> (ctl_w[0].used && ctl_w[0].active
			&& ctl_w[0].handle == $past(handle_q)))
		else $error("inserted slot missing at chain head");

	assert property (@(posedge clk) disable iff (!arst_n)
		(emit && e_kind == potc_pkg::KIND_REPLY && e_acc) |=> (handle_q != $past(handle_q)))
		else $error("handle counter did not advance on accepted register");

endmodule
